/* rtl/bde_pkg.sv */
package bde_pkg;

    typedef logic [15:0] t_ms16;
    typedef logic [31:0] t_ms32;

    // register indexes on the configuration port
    typedef enum logic {
        CFG_DEBOUNCE   = 1'b0,
        CFG_LONG_PRESS = 1'b1
    } t_cfg_idx;

    localparam t_ms16 DEBOUNCE_RST   = 16'd50;
    localparam t_ms16 LONG_PRESS_RST = 16'd1000;

    // pin levels are active low
    localparam logic LEVEL_PRESSED  = 1'b0;
    localparam logic LEVEL_RELEASED = 1'b1;

    typedef struct packed {
        logic  raw_level;
        t_ms32 now_ms;
        logic  ack_pressed;
        logic  ack_released;
        logic  ack_long;
    } t_item;

    typedef struct packed {
        logic is_down;
        logic press_seen;
        logic release_seen;
        logic long_seen;
    } t_result;

endpackage

/* rtl/bde_in_if.sv */
interface bde_in_if;
    logic        valid;
    logic        ready;
    logic        raw_level;
    logic [31:0] now_ms;
    logic        ack_pressed;
    logic        ack_released;
    logic        ack_long;

    modport source (output valid, output raw_level, output now_ms, output ack_pressed,
                    output ack_released, output ack_long, input ready);
    modport sink   (input valid, input raw_level, input now_ms, input ack_pressed,
                    input ack_released, input ack_long, output ready);
endinterface

/* rtl/bde_res_if.sv */
interface bde_res_if;
    logic valid;
    logic ready;
    logic is_down;
    logic press_seen;
    logic release_seen;
    logic long_seen;

    modport source (output valid, output is_down, output press_seen, output release_seen,
                    output long_seen, input ready);
    modport sink   (input valid, input is_down, input press_seen, input release_seen,
                    input long_seen, output ready);
endinterface

/* rtl/button_debounce_event_detector_top.sv */
// Button debounce and event detector.
// i_in carries one sample per beat: active-low raw pin level, a wrapping
// millisecond timestamp and three acknowledge bits. o_res returns exactly one
// beat per input beat: debounced is_down plus sticky press, release and
// long-press flags as they stand before the acknowledges clear them.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_idx
// (0 = debounce_ms, 1 = long_press_ms); write only while no beat is in flight.
// A beat is accepted into the input register, processed, and loaded into
// the result register once that is free; o_res shows it from then on.
// Throughput: one beat per cycle unless o_res stalls; all per-sample work
// is one pass of compare and subtract logic from input to result register.
// A stalled o_res holds its beat; the input register still takes one more
// beat, then i_in.ready drops until the result is taken.
// Reset clears both registers' valid bits and restores the defaults
// (50 ms, 1000 ms); the first beat after reset only loads the pin level.
module button_debounce_event_detector_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    bde_in_if.sink      i_in,
    bde_res_if.source   o_res
);
    import bde_pkg::*;

    logic    adv;
    logic    out_free;
    t_item   item;
    t_result res;

    bde_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_out_free (out_free),
        .o_adv      (adv),
        .o_item     (item)
    );

    bde_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_adv       (adv),
        .i_item      (item),
        .o_res       (res)
    );

    bde_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv),
        .i_res   (res),
        .o_res   (o_res),
        .o_free  (out_free)
    );

endmodule

/* rtl/bde_in_stage.sv */
module bde_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bde_in_if.sink        i_in,
    input  logic          i_out_free,
    output logic          o_adv,
    output bde_pkg::t_item o_item
);
    import bde_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  adv;

    assign adv        = r_valid && i_out_free;
    assign i_in.ready = !r_valid || i_out_free;
    assign o_adv      = adv;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_valid <= 1'b1;
        end else if (adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.raw_level    <= i_in.raw_level;
            r_item.now_ms       <= i_in.now_ms;
            r_item.ack_pressed  <= i_in.ack_pressed;
            r_item.ack_released <= i_in.ack_released;
            r_item.ack_long     <= i_in.ack_long;
        end
    end

endmodule

/* rtl/bde_core.sv */
module bde_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [15:0]      i_cfg_wdata,
    input  logic             i_adv,
    input  bde_pkg::t_item   i_item,
    output bde_pkg::t_result o_res
);
    import bde_pkg::*;

    t_ms16 r_debounce_ms;
    t_ms16 r_long_press_ms;

    logic  r_started;
    logic  r_raw_prev;
    logic  r_stable;
    t_ms32 r_change_mark;
    t_ms32 r_hold_start;
    logic  r_long_done;
    logic  r_press_flag;
    logic  r_release_flag;
    logic  r_long_flag;

    logic  n_started;
    logic  n_raw_prev;
    logic  n_stable;
    t_ms32 n_change_mark;
    t_ms32 n_hold_start;
    logic  n_long_done;
    logic  n_press_flag;
    logic  n_release_flag;
    logic  n_long_flag;

    logic  raw_changed;
    t_ms32 since_change;
    t_ms32 since_hold;
    logic  press_edge;
    logic  release_edge;
    logic  long_fire;
    logic  press_rep;
    logic  release_rep;
    logic  long_rep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms   <= DEBOUNCE_RST;
            r_long_press_ms <= LONG_PRESS_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DEBOUNCE:   r_debounce_ms   <= i_cfg_wdata;
                CFG_LONG_PRESS: r_long_press_ms <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // a raw change stamps the mark with now, so elapsed time is zero then
    assign raw_changed  = i_item.raw_level != r_raw_prev;
    assign since_change = raw_changed ? '0 : i_item.now_ms - r_change_mark;

    always_comb begin
        n_started      = r_started;
        n_raw_prev     = r_raw_prev;
        n_stable       = r_stable;
        n_change_mark  = r_change_mark;
        n_hold_start   = r_hold_start;
        n_long_done    = r_long_done;
        press_edge     = 1'b0;
        release_edge   = 1'b0;
        long_fire      = 1'b0;
        since_hold     = i_item.now_ms - r_hold_start;
        press_rep      = r_press_flag;
        release_rep    = r_release_flag;
        long_rep       = r_long_flag;

        if (!r_started) begin
            n_started  = 1'b1;
            n_raw_prev = i_item.raw_level;
            n_stable   = i_item.raw_level;
        end else begin
            if (raw_changed) begin
                n_change_mark = i_item.now_ms;
                n_raw_prev    = i_item.raw_level;
            end
            if (since_change >= {16'd0, r_debounce_ms}) begin
                n_stable = n_raw_prev;
            end
            press_edge   = (n_stable == LEVEL_PRESSED) && (r_stable == LEVEL_RELEASED);
            release_edge = (n_stable == LEVEL_RELEASED) && (r_stable == LEVEL_PRESSED);
            // a press restarts the hold time at this sample
            since_hold   = press_edge ? '0 : i_item.now_ms - r_hold_start;
            long_fire    = (n_stable == LEVEL_PRESSED) && !(r_long_done && !press_edge) &&
                           (since_hold >= {16'd0, r_long_press_ms});
            if (press_edge) begin
                n_hold_start = i_item.now_ms;
            end
            n_long_done = long_fire || (r_long_done && !press_edge && !release_edge);
            press_rep   = r_press_flag || press_edge;
            release_rep = r_release_flag || release_edge;
            long_rep    = !release_edge && (r_long_flag || long_fire);
        end

        n_press_flag   = press_rep && !i_item.ack_pressed;
        n_release_flag = release_rep && !i_item.ack_released;
        n_long_flag    = long_rep && !i_item.ack_long;
    end

    assign o_res.is_down      = n_stable == LEVEL_PRESSED;
    assign o_res.press_seen   = press_rep;
    assign o_res.release_seen = release_rep;
    assign o_res.long_seen    = long_rep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started      <= 1'b0;
            r_raw_prev     <= LEVEL_RELEASED;
            r_stable       <= LEVEL_RELEASED;
            r_change_mark  <= '0;
            r_hold_start   <= '0;
            r_long_done    <= 1'b0;
            r_press_flag   <= 1'b0;
            r_release_flag <= 1'b0;
            r_long_flag    <= 1'b0;
        end else if (i_adv) begin
            r_started      <= n_started;
            r_raw_prev     <= n_raw_prev;
            r_stable       <= n_stable;
            r_change_mark  <= n_change_mark;
            r_hold_start   <= n_hold_start;
            r_long_done    <= n_long_done;
            r_press_flag   <= n_press_flag;
            r_release_flag <= n_release_flag;
            r_long_flag    <= n_long_flag;
        end
    end

    // long-press state only lives while the debounced level is down
    a_long_flag_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_long_flag |-> r_long_done)
        else $error("long flag set without long-press done");
    a_long_done_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_long_done |-> (r_stable == LEVEL_PRESSED))
        else $error("long-press done while released");
    a_no_event_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_started |-> !(r_press_flag || r_release_flag || r_long_flag))
        else $error("event flag before first beat");
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> ($stable(r_stable) && $stable(r_raw_prev)))
        else $error("level state moved without a beat");

endmodule

/* rtl/bde_out_stage.sv */
module bde_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  bde_pkg::t_result i_res,
    bde_res_if.source        o_res,
    output logic             o_free
);
    import bde_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free             = !r_valid || o_res.ready;
    assign o_res.valid        = r_valid;
    assign o_res.is_down      = r_res.is_down;
    assign o_res.press_seen   = r_res.press_seen;
    assign o_res.release_seen = r_res.release_seen;
    assign o_res.long_seen    = r_res.long_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
    import bde_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int ITEMS_PER_SETTING = 75;
    localparam int SETTINGS_PER_PHASE = 5;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [15:0] i_cfg_wdata = '0;

    bde_in_if  in_if ();
    bde_res_if res_if ();

    button_debounce_event_detector_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_res       (res_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // mirror of the block's registers and button state
    t_ms16 mdl_debounce;
    t_ms16 mdl_long;
    logic  mdl_started;
    logic  mdl_raw_prev;
    logic  mdl_stable;
    logic  mdl_prev_stable;
    t_ms32 mdl_change_mark;
    t_ms32 mdl_hold_start;
    logic  mdl_long_done;
    logic  mdl_press_f;
    logic  mdl_release_f;
    logic  mdl_long_f;

    t_result     expected_res[$];
    int unsigned items_sent = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned quiet_cycles = 0;
    bit          failed = 1'b0;
    t_ms32       now_cursor = '0;

    function automatic t_result predict_button(t_item it);
        t_result r;
        t_ms32   since_change;
        t_ms32   since_hold;
        if (!mdl_started) begin
            // first sample only loads the level
            mdl_started     = 1'b1;
            mdl_raw_prev    = it.raw_level;
            mdl_stable      = it.raw_level;
            mdl_prev_stable = it.raw_level;
        end else begin
            if (it.raw_level != mdl_raw_prev) begin
                mdl_change_mark = it.now_ms;
                mdl_raw_prev    = it.raw_level;
            end
            since_change = it.now_ms - mdl_change_mark;
            if (since_change >= {16'd0, mdl_debounce})
                mdl_stable = mdl_raw_prev;
            if (mdl_stable == LEVEL_PRESSED && mdl_prev_stable == LEVEL_RELEASED) begin
                mdl_press_f    = 1'b1;
                mdl_hold_start = it.now_ms;
                mdl_long_done  = 1'b0;
            end
            if (mdl_stable == LEVEL_RELEASED && mdl_prev_stable == LEVEL_PRESSED) begin
                mdl_release_f = 1'b1;
                mdl_long_done = 1'b0;
                mdl_long_f    = 1'b0;
            end
            since_hold = it.now_ms - mdl_hold_start;
            if (mdl_stable == LEVEL_PRESSED && !mdl_long_done &&
                since_hold >= {16'd0, mdl_long}) begin
                mdl_long_f    = 1'b1;
                mdl_long_done = 1'b1;
            end
            mdl_prev_stable = mdl_stable;
        end
        r.is_down      = (mdl_stable == LEVEL_PRESSED);
        r.press_seen   = mdl_press_f;
        r.release_seen = mdl_release_f;
        r.long_seen    = mdl_long_f;
        if (it.ack_pressed)  mdl_press_f   = 1'b0;
        if (it.ack_released) mdl_release_f = 1'b0;
        if (it.ack_long)     mdl_long_f    = 1'b0;
        return r;
    endfunction

    // result side: random stalls, compare each beat with the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_res.size() == 0) begin
                $error("result beat with no prediction pending");
                failed = 1'b1;
            end else begin
                want = expected_res.pop_front();
                if (res_if.is_down !== want.is_down) begin
                    $error("is_down: expected %0b, got %0b", want.is_down, res_if.is_down);
                    failed = 1'b1;
                end
                if (res_if.press_seen !== want.press_seen) begin
                    $error("press_seen: expected %0b, got %0b",
                           want.press_seen, res_if.press_seen);
                    failed = 1'b1;
                end
                if (res_if.release_seen !== want.release_seen) begin
                    $error("release_seen: expected %0b, got %0b",
                           want.release_seen, res_if.release_seen);
                    failed = 1'b1;
                end
                if (res_if.long_seen !== want.long_seen) begin
                    $error("long_seen: expected %0b, got %0b",
                           want.long_seen, res_if.long_seen);
                    failed = 1'b1;
                end
            end
        end
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // valid stays high between back-to-back beats; it drops only on an idle cycle or a drain
    task automatic send_item(t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.raw_level    <= it.raw_level;
        in_if.now_ms       <= it.now_ms;
        in_if.ack_pressed  <= it.ack_pressed;
        in_if.ack_released <= it.ack_released;
        in_if.ack_long     <= it.ack_long;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        expected_res.push_back(predict_button(it));
        items_sent++;
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (expected_res.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, t_ms16 val);
        drain_results();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_DEBOUNCE)
            mdl_debounce = val;
        else
            mdl_long = val;
    endtask

    function automatic t_item item_at(logic raw, t_ms32 now, logic ap, logic ar, logic al);
        t_item it;
        it.raw_level    = raw;
        it.now_ms       = now;
        it.ack_pressed  = ap;
        it.ack_released = ar;
        it.ack_long     = al;
        now_cursor      = now;
        return it;
    endfunction

    // next sample dt ms after the previous one, acks at random
    function automatic t_item item_after(logic raw, int unsigned dt);
        return item_at(raw, now_cursor + dt, $urandom_range(99) < 40,
                       $urandom_range(99) < 40, $urandom_range(99) < 40);
    endfunction

    // bouncy press, hold of random length, bouncy release, rest
    task automatic button_cycle();
        int unsigned d = mdl_debounce;
        int unsigned l = mdl_long;
        logic        lvl;
        lvl = LEVEL_PRESSED;
        repeat ($urandom_range(0, 4)) begin
            send_item(item_after(lvl, $urandom_range(0, d / 2)));
            lvl = ~lvl;
        end
        send_item(item_after(LEVEL_PRESSED, $urandom_range(0, d / 2)));
        repeat ($urandom_range(1, 8))
            send_item(item_after(LEVEL_PRESSED, $urandom_range(0, (d + l) / 3 + 1)));
        lvl = LEVEL_RELEASED;
        repeat ($urandom_range(0, 4)) begin
            send_item(item_after(lvl, $urandom_range(0, d / 2)));
            lvl = ~lvl;
        end
        repeat ($urandom_range(1, 3))
            send_item(item_after(LEVEL_RELEASED, $urandom_range(0, d + 2)));
    endtask

    // random levels, random steps and the odd jump to an arbitrary timestamp
    task automatic noise_burst();
        repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(3) == 0)
                now_cursor = $urandom;
            send_item(item_after(1'($urandom_range(1)),
                                 $urandom_range(0, 2 * mdl_debounce + 1)));
        end
    endtask

    task automatic pick_random_setting();
        case ($urandom_range(5))
            0:       write_reg(CFG_DEBOUNCE, 16'd0);
            1:       write_reg(CFG_DEBOUNCE, 16'hFFFF);
            default: write_reg(CFG_DEBOUNCE, t_ms16'($urandom_range(1, 20)));
        endcase
        case ($urandom_range(5))
            0:       write_reg(CFG_LONG_PRESS, 16'd0);
            1:       write_reg(CFG_LONG_PRESS, 16'hFFFF);
            default: write_reg(CFG_LONG_PRESS, t_ms16'($urandom_range(1, 150)));
        endcase
    endtask

    task automatic test_defaults_and_first_item();
        // first item loads pressed without any event
        send_item(item_at(LEVEL_PRESSED,  32'd1000, 1'b0, 1'b0, 1'b0));
        send_item(item_at(LEVEL_PRESSED,  32'd1010, 1'b0, 1'b0, 1'b0));
        send_item(item_at(LEVEL_RELEASED, 32'd1020, 1'b0, 1'b0, 1'b1));
        send_item(item_at(LEVEL_PRESSED,  32'd1030, 1'b0, 1'b0, 1'b0));
        send_item(item_at(LEVEL_RELEASED, 32'd1040, 1'b0, 1'b0, 1'b0));
        send_item(item_at(LEVEL_RELEASED, 32'd1100, 1'b0, 1'b1, 1'b0));
        send_item(item_at(LEVEL_PRESSED,  32'd1200, 1'b0, 1'b0, 1'b0));
        send_item(item_at(LEVEL_PRESSED,  32'd1249, 1'b0, 1'b0, 1'b0));
        send_item(item_at(LEVEL_PRESSED,  32'd1250, 1'b1, 1'b0, 1'b0));
        send_item(item_at(LEVEL_PRESSED,  32'd2249, 1'b0, 1'b0, 1'b0));
        send_item(item_at(LEVEL_PRESSED,  32'd2250, 1'b0, 1'b0, 1'b1));
        send_item(item_at(LEVEL_RELEASED, 32'd2400, 1'b0, 1'b0, 1'b0));
        send_item(item_at(LEVEL_RELEASED, 32'd2450, 1'b1, 1'b1, 1'b1));
    endtask

    task automatic test_zero_times();
        write_reg(CFG_DEBOUNCE, 16'd0);
        write_reg(CFG_LONG_PRESS, 16'd0);
        // press and long press on the same sample
        send_item(item_at(LEVEL_PRESSED,  32'd3000, 1'b1, 1'b0, 1'b1));
        send_item(item_at(LEVEL_RELEASED, 32'd3000, 1'b0, 1'b1, 1'b0));
        send_item(item_at(LEVEL_PRESSED,  32'd3001, 1'b1, 1'b1, 1'b1));
    endtask

    task automatic test_max_times_and_wrap();
        write_reg(CFG_DEBOUNCE, 16'hFFFF);
        write_reg(CFG_LONG_PRESS, 16'hFFFF);
        send_item(item_at(LEVEL_RELEASED, 32'hFFFF_FFF0, 1'b1, 1'b1, 1'b1));
        // elapsed time crosses the 2^32 wrap
        send_item(item_at(LEVEL_RELEASED, 32'h0000_FFEF, 1'b0, 1'b0, 1'b0));
        send_item(item_at(LEVEL_PRESSED,  32'h0001_0000, 1'b1, 1'b1, 1'b0));
        send_item(item_at(LEVEL_PRESSED,  32'h0002_0000, 1'b0, 1'b0, 1'b0));
        send_item(item_at(LEVEL_PRESSED,  32'h0002_FFFF, 1'b1, 1'b0, 1'b0));
        // timestamp going backwards reads as a huge elapsed time
        send_item(item_at(LEVEL_RELEASED, 32'h0000_0005, 1'b1, 1'b1, 1'b1));
    endtask

    task automatic test_random_phase(int unsigned idle_pct, int unsigned stall_pct,
                                     bit pause_mid);
        int unsigned start;
        bit          paused;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        paused         = 1'b0;
        for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
            pick_random_setting();
            start = items_sent;
            while (items_sent - start < ITEMS_PER_SETTING) begin
                if ($urandom_range(99) < 85)
                    button_cycle();
                else
                    noise_burst();
                if (pause_mid && !paused && s == 2 && items_sent - start > 30) begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end
    endtask

    initial begin
        in_if.valid        = 1'b0;
        in_if.raw_level    = LEVEL_RELEASED;
        in_if.now_ms       = '0;
        in_if.ack_pressed  = 1'b0;
        in_if.ack_released = 1'b0;
        in_if.ack_long     = 1'b0;
        res_if.ready       = 1'b0;

        mdl_debounce    = DEBOUNCE_RST;
        mdl_long        = LONG_PRESS_RST;
        mdl_started     = 1'b0;
        mdl_raw_prev    = LEVEL_RELEASED;
        mdl_stable      = LEVEL_RELEASED;
        mdl_prev_stable = LEVEL_RELEASED;
        mdl_change_mark = '0;
        mdl_hold_start  = '0;
        mdl_long_done   = 1'b0;
        mdl_press_f     = 1'b0;
        mdl_release_f   = 1'b0;
        mdl_long_f      = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults_and_first_item();
        test_zero_times();
        test_max_times_and_wrap();
        test_random_phase(0, 0, 1'b0);
        test_random_phase(58, 0, 1'b1);
        test_random_phase(0, 58, 1'b0);
        test_random_phase(32, 32, 1'b0);

        drain_results();
        repeat (10) @(posedge i_clk);
        if (!failed && expected_res.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
